@@ sv/tafc_pkg.sv @@
`timescale 1ns / 1ps

package tafc_pkg;

	// Request item: start of a search or a tuner status report
	typedef struct packed {
		logic        op;
		logic [15:0] start_freq;
		logic        search_up;
		logic        wrap_mode;
		logic [7:0]  afc_status;
		logic        signal_present;
		logic        stop_request;
	} req_t;

	// Result item: frequency to tune, its band, and the search outcome
	typedef struct packed {
		logic [15:0] tune_freq;
		logic [1:0]  band;
		logic [1:0]  outcome;
	} res_t;

	typedef enum logic {
		OP_START  = 1'b0,
		OP_STATUS = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		OUT_KEEP     = 2'd0,
		OUT_FOUND    = 2'd1,
		OUT_NOTFOUND = 2'd2,
		OUT_ABORT    = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		BAND_LOW  = 2'd0,
		BAND_MID  = 2'd1,
		BAND_HIGH = 2'd2
	} band_t;

	typedef enum logic [2:0] {
		REG_MIN_FREQ  = 3'd0,
		REG_MAX_FREQ  = 3'd1,
		REG_SKIP_UNIT = 3'd2,
		REG_LOW_EDGE  = 3'd3,
		REG_HIGH_EDGE = 3'd4
	} reg_idx_t;

	localparam int unsigned AFC_WIN_BIT  = 6;
	localparam logic [2:0]  AFC_CENTERED = 3'd2;
	localparam logic [2:0]  AFC_CODE_0   = 3'd0;
	localparam logic [2:0]  AFC_CODE_1   = 3'd1;
	localparam logic [2:0]  AFC_CODE_3   = 3'd3;
	localparam logic [2:0]  AFC_CODE_4   = 3'd4;
	localparam logic [2:0]  AFC_CODE_5   = 3'd5;
	localparam logic [2:0]  AFC_CODE_7   = 3'd7;

	localparam logic [15:0] MIN_FREQ_RST  = 16'h0000;
	localparam logic [15:0] MAX_FREQ_RST  = 16'hFFFF;
	localparam logic [13:0] SKIP_UNIT_RST = 14'd1;
	localparam logic [15:0] EDGE_RST      = 16'h0000;

endpackage

@@ sv/tuner_afc_channel_search.sv @@
`timescale 1ns / 1ps

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+------------------------
// req      | in        | req_valid / req_stall   | req_data  (tafc_pkg::req_t)
// res      | out       | res_valid / res_stall   | res_data  (tafc_pkg::res_t)
// apb      | in        | psel/penable/pwrite     | paddr, pwdata, prdata
//
// One request per cycle unless stalled; each result is computed between the input
// register and the result register, and is valid from the result register.
// Reset clears the search state to idle and loads register defaults.
// A stalled result holds the result register and a full input register;
// requests stall only while both are full and the result is stalled.

module tuner_afc_channel_search (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  tafc_pkg::req_t     req_data,
	output logic               res_valid,
	input  logic               res_stall,
	output tafc_pkg::res_t     res_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// configuration registers
	logic [15:0] min_freq_q, max_freq_q, low_edge_q, high_edge_q;
	logic [13:0] skip_unit_q;

	// search state
	logic [15:0] cur_freq_q, base_freq_q;
	logic        wrapped_q, dir_up_q, fine_q, active_q;

	// pipeline
	tafc_pkg::req_t req_s1;
	logic           vld_s1;
	tafc_pkg::res_t res_s2;
	logic           vld_s2;

	logic           adv_s1;
	logic           cfg_wr;
	logic [2:0]     cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_freq_q  <= tafc_pkg::MIN_FREQ_RST;
			max_freq_q  <= tafc_pkg::MAX_FREQ_RST;
			skip_unit_q <= tafc_pkg::SKIP_UNIT_RST;
			low_edge_q  <= tafc_pkg::EDGE_RST;
			high_edge_q <= tafc_pkg::EDGE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				tafc_pkg::REG_MIN_FREQ:  min_freq_q  <= pwdata[15:0];
				tafc_pkg::REG_MAX_FREQ:  max_freq_q  <= pwdata[15:0];
				tafc_pkg::REG_SKIP_UNIT: skip_unit_q <= pwdata[13:0];
				tafc_pkg::REG_LOW_EDGE:  low_edge_q  <= pwdata[15:0];
				tafc_pkg::REG_HIGH_EDGE: high_edge_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			tafc_pkg::REG_MIN_FREQ:  prdata = {16'h0000, min_freq_q};
			tafc_pkg::REG_MAX_FREQ:  prdata = {16'h0000, max_freq_q};
			tafc_pkg::REG_SKIP_UNIT: prdata = {18'd0, skip_unit_q};
			tafc_pkg::REG_LOW_EDGE:  prdata = {16'h0000, low_edge_q};
			tafc_pkg::REG_HIGH_EDGE: prdata = {16'h0000, high_edge_q};
			default:                 prdata = 32'h0000_0000;
		endcase
	end

	// handshake
	assign adv_s1    = vld_s1 & (~vld_s2 | ~res_stall);
	assign req_stall = vld_s1 & vld_s2 & res_stall;
	assign res_valid = vld_s2;
	assign res_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!req_stall) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
	end

	// step computation
	logic        in_win, centered, coarse_back, do_sub;
	logic [2:0]  code;
	logic [15:0] step, delta, stepped, jump;
	logic [15:0] nxt_cur, nxt_base, res_freq;
	logic        nxt_wrapped, nxt_dir, nxt_fine, nxt_active;
	logic [1:0]  res_out;

	function automatic logic [1:0] band_of(input logic [15:0] f,
	                                       input logic [15:0] lo,
	                                       input logic [15:0] hi);
		if (f < lo)
			band_of = tafc_pkg::BAND_LOW;
		else if (f < hi)
			band_of = tafc_pkg::BAND_MID;
		else
			band_of = tafc_pkg::BAND_HIGH;
	endfunction

	always_comb begin
		in_win   = req_s1.afc_status[tafc_pkg::AFC_WIN_BIT];
		code     = req_s1.afc_status[2:0];
		centered = in_win && (code == tafc_pkg::AFC_CENTERED);
		jump     = {skip_unit_q, 2'b00};

		if (fine_q) begin
			if (!in_win)
				step = 16'd2;
			else if (dir_up_q || code <= tafc_pkg::AFC_CODE_4)
				step = 16'd1;
			else
				step = 16'd2;
		end else begin
			if (!in_win)
				step = 16'd4;
			else begin
				case (code) inside
					tafc_pkg::AFC_CODE_0, tafc_pkg::AFC_CODE_4: step = 16'd2;
					tafc_pkg::AFC_CODE_1, tafc_pkg::AFC_CODE_3: step = 16'd1;
					default:                                    step = 16'd4;
				endcase
			end
		end

		// coarse up pulls back for low codes
		coarse_back = !fine_q && dir_up_q && in_win && (code <= tafc_pkg::AFC_CODE_1);
		delta       = centered ? jump : step;
		do_sub      = centered ? !dir_up_q : (coarse_back || !dir_up_q);
		stepped     = do_sub ? (cur_freq_q - delta) : (cur_freq_q + delta);

		nxt_cur     = cur_freq_q;
		nxt_base    = base_freq_q;
		nxt_wrapped = wrapped_q;
		nxt_dir     = dir_up_q;
		nxt_fine    = fine_q;
		nxt_active  = active_q;
		res_freq    = cur_freq_q;
		res_out     = tafc_pkg::OUT_KEEP;

		if (req_s1.op == tafc_pkg::OP_START) begin
			nxt_cur     = req_s1.start_freq;
			nxt_base    = req_s1.start_freq;
			nxt_dir     = req_s1.search_up;
			nxt_fine    = req_s1.wrap_mode;
			nxt_wrapped = 1'b0;
			nxt_active  = 1'b1;
			res_freq    = req_s1.start_freq;
		end else if (!active_q) begin
			res_out = tafc_pkg::OUT_NOTFOUND;
		end else if (req_s1.stop_request) begin
			nxt_active = 1'b0;
			res_out    = tafc_pkg::OUT_ABORT;
		end else if (centered && req_s1.signal_present) begin
			nxt_active = 1'b0;
			res_out    = tafc_pkg::OUT_FOUND;
		end else begin
			nxt_cur  = stepped;
			res_freq = stepped;
			if (!fine_q) begin
				if (dir_up_q ? (stepped > max_freq_q) : (stepped < min_freq_q)) begin
					nxt_active = 1'b0;
					res_out    = tafc_pkg::OUT_NOTFOUND;
				end
			end else if (wrapped_q &&
			             (dir_up_q ? (stepped > base_freq_q) : (stepped < base_freq_q))) begin
				nxt_active = 1'b0;
				res_out    = tafc_pkg::OUT_NOTFOUND;
			end else if (dir_up_q && stepped > max_freq_q) begin
				nxt_cur     = min_freq_q;
				res_freq    = min_freq_q;
				nxt_wrapped = 1'b1;
			end else if (!dir_up_q && stepped < min_freq_q) begin
				nxt_cur     = max_freq_q;
				res_freq    = max_freq_q;
				nxt_wrapped = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_freq_q  <= 16'h0000;
			base_freq_q <= 16'h0000;
			wrapped_q   <= 1'b0;
			dir_up_q    <= 1'b0;
			fine_q      <= 1'b0;
			active_q    <= 1'b0;
		end else if (adv_s1) begin
			cur_freq_q  <= nxt_cur;
			base_freq_q <= nxt_base;
			wrapped_q   <= nxt_wrapped;
			dir_up_q    <= nxt_dir;
			fine_q      <= nxt_fine;
			active_q    <= nxt_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || !res_stall) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2.tune_freq <= res_freq;
			res_s2.band      <= band_of(res_freq, low_edge_q, high_edge_q);
			res_s2.outcome   <= res_out;
		end
	end

endmodule

@@ test/tb_tuner_afc_channel_search.sv @@
`timescale 1ns / 1ps

module tb_tuner_afc_channel_search;

	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned ITEMS_PER_PHASE = 60;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	tafc_pkg::req_t req_data = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	tafc_pkg::res_t res_data;
	logic           psel = 1'b0;
	logic           penable = 1'b0;
	logic           pwrite = 1'b0;
	logic [4:0]     paddr = '0;
	logic [31:0]    pwdata = '0;
	logic [31:0]    prdata;
	logic           pready;

	tuner_afc_channel_search uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// register copies
	logic [15:0] band_min = tafc_pkg::MIN_FREQ_RST;
	logic [15:0] band_max = tafc_pkg::MAX_FREQ_RST;
	logic [13:0] skip_quarter = tafc_pkg::SKIP_UNIT_RST;
	logic [15:0] low_edge = tafc_pkg::EDGE_RST;
	logic [15:0] high_edge = tafc_pkg::EDGE_RST;

	// search state
	logic [15:0] srch_freq = '0;
	logic [15:0] srch_base = '0;
	logic        srch_wrapped = 1'b0;
	logic        srch_up = 1'b0;
	logic        srch_fine = 1'b0;
	logic        srch_active = 1'b0;

	tafc_pkg::req_t pending_reqs[$];
	tafc_pkg::res_t expected_res[$];
	tafc_pkg::res_t want;
	logic        req_taken = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned fail_count = 0;
	int unsigned reqs_taken = 0;
	int unsigned results_checked = 0;
	int unsigned n_found = 0;
	int unsigned n_notfound = 0;
	int unsigned n_abort = 0;
	int unsigned quiet_cycles = 0;

	initial forever #5 clk = ~clk;

	function automatic tafc_pkg::band_t band_for(logic [15:0] f);
		if (f < low_edge)
			return tafc_pkg::BAND_LOW;
		if (f < high_edge)
			return tafc_pkg::BAND_MID;
		return tafc_pkg::BAND_HIGH;
	endfunction

	function automatic tafc_pkg::res_t search_result(logic [15:0] f,
			tafc_pkg::outcome_t oc);
		tafc_pkg::res_t r;
		r.tune_freq = f;
		r.band = band_for(f);
		r.outcome = oc;
		return r;
	endfunction

	// step magnitude for any AFC reading other than centered in window
	function automatic logic [15:0] afc_step(logic in_win, logic [2:0] code);
		if (srch_fine) begin
			if (!in_win)
				return 16'd2;
			if (srch_up || code <= tafc_pkg::AFC_CODE_4)
				return 16'd1;
			return 16'd2;
		end
		if (!in_win)
			return 16'd4;
		case (code) inside
		tafc_pkg::AFC_CODE_0, tafc_pkg::AFC_CODE_4: return 16'd2;
		tafc_pkg::AFC_CODE_1, tafc_pkg::AFC_CODE_3: return 16'd1;
		default: return 16'd4;
		endcase
	endfunction

	function automatic tafc_pkg::res_t predict_search(tafc_pkg::req_t r);
		logic        in_win;
		logic        centered;
		logic [2:0]  code;
		logic [15:0] s;
		logic [15:0] f;
		in_win = r.afc_status[tafc_pkg::AFC_WIN_BIT];
		code = r.afc_status[2:0];
		centered = in_win && (code == tafc_pkg::AFC_CENTERED);
		if (r.op == tafc_pkg::OP_START) begin
			srch_freq = r.start_freq;
			srch_base = r.start_freq;
			srch_up = r.search_up;
			srch_fine = r.wrap_mode;
			srch_wrapped = 1'b0;
			srch_active = 1'b1;
			return search_result(srch_freq, tafc_pkg::OUT_KEEP);
		end
		if (!srch_active)
			return search_result(srch_freq, tafc_pkg::OUT_NOTFOUND);
		if (r.stop_request) begin
			srch_active = 1'b0;
			return search_result(srch_freq, tafc_pkg::OUT_ABORT);
		end
		if (centered && r.signal_present) begin
			srch_active = 1'b0;
			return search_result(srch_freq, tafc_pkg::OUT_FOUND);
		end
		if (centered)
			s = {skip_quarter, 2'b00};
		else
			s = afc_step(in_win, code);
		// coarse upward search backs off on the low in-window codes
		if (!srch_fine && srch_up && in_win && code <= tafc_pkg::AFC_CODE_1)
			f = srch_freq - s;
		else if (srch_up)
			f = srch_freq + s;
		else
			f = srch_freq - s;
		srch_freq = f;
		if (!srch_fine) begin
			if (srch_up ? (f > band_max) : (f < band_min)) begin
				srch_active = 1'b0;
				return search_result(f, tafc_pkg::OUT_NOTFOUND);
			end
			return search_result(f, tafc_pkg::OUT_KEEP);
		end
		if (srch_wrapped && (srch_up ? (f > srch_base) : (f < srch_base))) begin
			srch_active = 1'b0;
			return search_result(f, tafc_pkg::OUT_NOTFOUND);
		end
		if (srch_up ? (f > band_max) : (f < band_min)) begin
			f = srch_up ? band_min : band_max;
			srch_wrapped = 1'b1;
		end
		srch_freq = f;
		return search_result(f, tafc_pkg::OUT_KEEP);
	endfunction

	function automatic logic [7:0] afc_byte(logic in_win, logic [2:0] code);
		logic [31:0] raw;
		raw = $urandom();
		raw[tafc_pkg::AFC_WIN_BIT] = in_win;
		raw[2:0] = code;
		return raw[7:0];
	endfunction

	function automatic logic [15:0] pick_start_freq();
		logic [31:0] pick;
		case ($urandom_range(0, 9))
		0: pick = 32'h0000;
		1: pick = 32'hFFFF;
		2: pick = {16'h0, band_min};
		3: pick = {16'h0, band_max};
		default: pick = $urandom_range(band_min, band_max);
		endcase
		return pick[15:0];
	endfunction

	task automatic queue_start(logic [15:0] freq, logic up, logic fine);
		logic [31:0]    raw;
		tafc_pkg::req_t r;
		raw = $urandom();
		r = raw[$bits(tafc_pkg::req_t)-1:0];
		r.op = tafc_pkg::OP_START;
		r.start_freq = freq;
		r.search_up = up;
		r.wrap_mode = fine;
		pending_reqs.push_back(r);
	endtask

	task automatic queue_status(logic [7:0] afc, logic sig, logic stop);
		logic [31:0]    raw;
		tafc_pkg::req_t r;
		raw = $urandom();
		r = raw[$bits(tafc_pkg::req_t)-1:0];
		r.op = tafc_pkg::OP_STATUS;
		r.afc_status = afc;
		r.signal_present = sig;
		r.stop_request = stop;
		pending_reqs.push_back(r);
	endtask

	task automatic write_reg(tafc_pkg::reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
		tafc_pkg::REG_MIN_FREQ:  band_min = value[15:0];
		tafc_pkg::REG_MAX_FREQ:  band_max = value[15:0];
		tafc_pkg::REG_SKIP_UNIT: skip_quarter = value[13:0];
		tafc_pkg::REG_LOW_EDGE:  low_edge = value[15:0];
		tafc_pkg::REG_HIGH_EDGE: high_edge = value[15:0];
		default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_band(logic [15:0] lo, logic [15:0] hi, logic [13:0] skip,
			logic [15:0] le, logic [15:0] he);
		write_reg(tafc_pkg::REG_MIN_FREQ, {16'h0, lo});
		write_reg(tafc_pkg::REG_MAX_FREQ, {16'h0, hi});
		write_reg(tafc_pkg::REG_SKIP_UNIT, {18'h0, skip});
		write_reg(tafc_pkg::REG_LOW_EDGE, {16'h0, le});
		write_reg(tafc_pkg::REG_HIGH_EDGE, {16'h0, he});
	endtask

	// mostly complete searches with random AFC readings, some raw noise
	task automatic queue_random_searches(int unsigned n_items);
		int unsigned queued;
		int unsigned steps;
		logic [31:0] raw;
		logic [2:0]  code;
		queued = 0;
		while (queued < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				raw = $urandom();
				pending_reqs.push_back(raw[$bits(tafc_pkg::req_t)-1:0]);
				queued++;
			end else begin
				queue_start(pick_start_freq(), $urandom_range(0, 1) != 0,
					$urandom_range(0, 1) != 0);
				steps = $urandom_range(1, 40);
				repeat (steps) begin
					raw = $urandom();
					code = ($urandom_range(0, 99) < 40) ? tafc_pkg::AFC_CENTERED : raw[2:0];
					queue_status(afc_byte($urandom_range(0, 99) < 85, code),
						$urandom_range(0, 99) < 8, $urandom_range(0, 99) < 3);
				end
				queued += steps + 1;
			end
		end
	endtask

	task automatic drain_searches();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || req_valid || expected_res.size() != 0);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req_data <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	// monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				expected_res.push_back(predict_search(req_data));
				reqs_taken++;
			end
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					$error("unexpected result: tune_freq %0d band %0d outcome %0d",
						res_data.tune_freq, res_data.band, res_data.outcome);
					fail_count++;
				end else begin
					want = expected_res.pop_front();
					results_checked++;
					if (res_data.tune_freq !== want.tune_freq) begin
						$error("tune_freq: expected %0d, got %0d", want.tune_freq,
							res_data.tune_freq);
						fail_count++;
					end
					if (res_data.band !== want.band) begin
						$error("band: expected %0d, got %0d", want.band, res_data.band);
						fail_count++;
					end
					if (res_data.outcome !== want.outcome) begin
						$error("outcome: expected %0d, got %0d", want.outcome,
							res_data.outcome);
						fail_count++;
					end
					case (want.outcome)
					tafc_pkg::OUT_FOUND:    n_found++;
					tafc_pkg::OUT_NOTFOUND: n_notfound++;
					tafc_pkg::OUT_ABORT:    n_abort++;
					default: ;
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", quiet_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [31:0] lo;
		logic [31:0] span;
		logic [31:0] skip;
		logic [31:0] le;
		logic [31:0] he;
		logic [2:0]  code;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 17;
		recv_stall_pct = 77;

		program_band(16'd1000, 16'd1040, 14'd5, 16'd1010, 16'd1030);
		// status while idle: every flag set, still answers not found
		queue_status(8'hFF, 1'b1, 1'b1);
		// coarse up through every in-window code, then a skip and a hit
		queue_start(16'd1000, 1'b1, 1'b0);
		queue_status(afc_byte(1'b0, tafc_pkg::AFC_CENTERED), 1'b0, 1'b0);
		for (int c = 0; c < 8; c++) begin
			code = c[2:0];
			if (code != tafc_pkg::AFC_CENTERED)
				queue_status(afc_byte(1'b1, code), 1'b0, 1'b0);
		end
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CENTERED), 1'b0, 1'b0);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CENTERED), 1'b1, 1'b0);
		// coarse down, restart while active, then run off the low edge
		queue_start(16'd1020, 1'b0, 1'b0);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CODE_0), 1'b0, 1'b0);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CODE_4), 1'b0, 1'b0);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CODE_7), 1'b0, 1'b0);
		queue_start(16'd1003, 1'b0, 1'b0);
		queue_status(afc_byte(1'b0, tafc_pkg::AFC_CODE_1), 1'b0, 1'b0);
		// fine up: wrap to the bottom, then pass the start again
		queue_start(16'd1035, 1'b1, 1'b1);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CENTERED), 1'b0, 1'b0);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CENTERED), 1'b0, 1'b0);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CENTERED), 1'b0, 1'b0);
		// fine down: mirror of the above
		queue_start(16'd1005, 1'b0, 1'b1);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CODE_5), 1'b0, 1'b0);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CENTERED), 1'b0, 1'b0);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CODE_1), 1'b0, 1'b0);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CENTERED), 1'b0, 1'b0);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CENTERED), 1'b0, 1'b0);
		// stop wins over a centered hit
		queue_start(16'd1020, 1'b1, 1'b1);
		queue_status(afc_byte(1'b1, tafc_pkg::AFC_CENTERED), 1'b1, 1'b1);
		drain_searches();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 77;
				recv_stall_pct = 17;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			case (ph)
			0: program_band(16'h0000, 16'hFFFF, 14'h3FFF, 16'h0000, 16'hFFFF);
			2: program_band(16'hFFFF, 16'h0000, 14'h0000, 16'hFFFF, 16'h0000);
			default: begin
				lo = $urandom_range(0, 65000);
				span = $urandom_range(16, 400);
				skip = $urandom_range(0, 24);
				le = $urandom_range(lo, lo + span);
				he = $urandom_range(le, lo + span);
				program_band(lo[15:0], lo[15:0] + span[15:0], skip[13:0], le[15:0],
					he[15:0]);
			end
			endcase
			queue_random_searches(ITEMS_PER_PHASE);
			drain_searches();
		end

		repeat (4) @(posedge clk);
		$display("checked %0d results for %0d requests over 7 band settings",
			results_checked, reqs_taken);
		$display("searches ended: %0d found, %0d not found, %0d aborted",
			n_found, n_notfound, n_abort);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
sv/tafc_pkg.sv
sv/tuner_afc_channel_search.sv
test/tb_tuner_afc_channel_search.sv
